@@ design/rtks_pkg.sv @@
// Shared constants and types for the row top-k sparsify/normalize block.
`default_nettype none

package rtks_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_KEPT       = 64;

    localparam int VALUE_W  = 16;
    localparam int COL_W    = 10;
    localparam int CNT_W    = 7;
    localparam int SUM_W    = 22;
    localparam int REM_W    = SUM_W + 1;
    localparam int COLCNT_W = $clog2(MAX_ROW_LENGTH) + 1;
    localparam int KIDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int STEP_W   = $clog2(VALUE_W);

    localparam logic [CNT_W-1:0] TOP_COUNT_RESET = CNT_W'(20);

    // cell operations
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_INSERT     = 2'd1;
    localparam logic [1:0] CELL_TAKE_RIGHT = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       ins_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/rtks_cell.sv @@
// One cell of the sorted insertion chain: holds one kept value and its column.
`default_nettype none

module rtks_cell
    import rtks_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [VALUE_W-1:0] sample_value,
    input  wire logic [COL_W-1:0]   sample_col,
    input  wire logic               in_range,
    input  wire logic               left_gt,
    input  wire logic [VALUE_W-1:0] left_value,
    input  wire logic [COL_W-1:0]   left_col,
    input  wire logic               left_valid,
    input  wire logic [VALUE_W-1:0] right_value,
    input  wire logic [COL_W-1:0]   right_col,
    input  wire logic               right_valid,
    output logic [VALUE_W-1:0]      value,
    output logic [COL_W-1:0]        col,
    output logic                    valid,
    output logic                    gt
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               valid_reg, valid_next;

    // strict compare: an equal sample lands after the earlier column
    assign gt = ctrl.ins_en && in_range && (!valid_reg || (sample_value > value_reg));

    always_comb begin
        value_next = value_reg;
        col_next   = col_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!in_range) begin
                    valid_next = 1'b0;
                end else if (left_gt) begin
                    value_next = left_value;
                    col_next   = left_col;
                    valid_next = left_valid;
                end else if (gt) begin
                    value_next = sample_value;
                    col_next   = sample_col;
                    valid_next = 1'b1;
                end
            end
            CELL_TAKE_RIGHT: begin
                value_next = right_value;
                col_next   = right_col;
                valid_next = right_valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        col_reg   <= col_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign col   = col_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ design/rtks_div.sv @@
// Bit-serial restoring divider for value * 2^16 / sum, saturating at 1.0.
`default_nettype none

module rtks_div
    import rtks_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [SUM_W-1:0]   divisor,
    output logic                    done,
    output logic [VALUE_W-1:0]      quotient
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0]   dsr_reg, dsr_next;
    logic [REM_W-1:0]   rem_shl;
    logic               ge;

    assign rem_shl = {rem_reg[REM_W-2:0], 1'b0};
    assign ge      = rem_shl >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            dsr_next = divisor;
            if (divisor == '0) begin
                quo_next  = '0;
                done_next = 1'b1;
            end else if (SUM_W'(dividend) == divisor) begin
                // weight of exactly 1.0 saturates
                quo_next  = '1;
                done_next = 1'b1;
            end else begin
                rem_next  = REM_W'(dividend);
                quo_next  = '0;
                step_next = STEP_W'(VALUE_W - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? (rem_shl - REM_W'(dsr_reg)) : rem_shl;
            quo_next = {quo_reg[VALUE_W-2:0], ge};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ design/row_top_k_sparsify_normalize.sv @@
// Top level: keeps the top_count largest samples of a row and emits them normalized.
// Input: one sample per cycle while loading.
// After row_end: a pass rotates the cell chain once to form the kept sum.
// Then each kept entry in turn goes through the bit-serial divider and is emitted.
// The next row is accepted once the last result of the row has been taken.
// Reset (aresetn low, synchronous): control and valid bits clear, top_count returns to 20.
`default_nettype none

module row_top_k_sparsify_normalize
    import rtks_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // config
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   cfg_data,
    // sample stream
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_sample_value,
    input  wire logic               s_row_end,
    // result stream
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COL_W-1:0]        m_column_index,
    output logic [VALUE_W-1:0]      m_weight,
    output logic                    m_run_end
);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_SUM     = 3'd1;
    localparam logic [2:0] ST_DIVGO   = 3'd2;
    localparam logic [2:0] ST_DIVWAIT = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    top_count_reg;
    logic [COLCNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [KIDX_W-1:0]   pass_cnt_reg, pass_cnt_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [VALUE_W-1:0]  out_w_reg, out_w_next;
    logic                out_end_reg, out_end_next;

    logic               accept_in;
    logic [CNT_W-1:0]   limit;
    cell_ctrl_t         ctrl;
    logic               div_start;
    logic               div_done;
    logic [VALUE_W-1:0] div_q;

    // chain wiring
    logic [VALUE_W-1:0] c_value [MAX_KEPT];
    logic [COL_W-1:0]   c_col   [MAX_KEPT];
    logic               c_valid [MAX_KEPT];
    logic               c_gt    [MAX_KEPT];
    logic [VALUE_W-1:0] r_value [MAX_KEPT];
    logic [COL_W-1:0]   r_col   [MAX_KEPT];
    logic               r_valid [MAX_KEPT];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign accept_in = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_OUT);

    // effective limit: zero acts as one, capped at the chain length
    always_comb begin
        if (top_count_reg == '0) begin
            limit = CNT_W'(1);
        end else if (top_count_reg > CNT_W'(MAX_KEPT)) begin
            limit = CNT_W'(MAX_KEPT);
        end else begin
            limit = top_count_reg;
        end
    end

    // cell control: insert on a sample, shift toward cell 0 during the sum
    // pass (rotating) and after each taken result (tail fills invalid)
    always_comb begin
        ctrl.ins_en = (col_cnt_reg < COLCNT_W'(MAX_ROW_LENGTH));
        if (accept_in) begin
            ctrl.op = CELL_INSERT;
        end else if ((state_reg == ST_SUM) || ((state_reg == ST_OUT) && m_ready)) begin
            ctrl.op = CELL_TAKE_RIGHT;
        end else begin
            ctrl.op = CELL_HOLD;
        end
    end

    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        logic               l_gt;
        logic [VALUE_W-1:0] l_value;
        logic [COL_W-1:0]   l_col;
        logic               l_valid;

        if (i == 0) begin : g_first
            assign l_gt    = 1'b0;
            assign l_value = '0;
            assign l_col   = '0;
            assign l_valid = 1'b0;
        end else begin : g_mid
            assign l_gt    = c_gt[i-1];
            assign l_value = c_value[i-1];
            assign l_col   = c_col[i-1];
            assign l_valid = c_valid[i-1];
        end

        if (i == MAX_KEPT - 1) begin : g_last
            // tail wraps to the head only during the sum pass
            assign r_value[i] = c_value[0];
            assign r_col[i]   = c_col[0];
            assign r_valid[i] = (state_reg == ST_SUM) && c_valid[0];
        end else begin : g_inner
            assign r_value[i] = c_value[i+1];
            assign r_col[i]   = c_col[i+1];
            assign r_valid[i] = c_valid[i+1];
        end

        rtks_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .sample_value (s_sample_value),
            .sample_col   (col_cnt_reg[COL_W-1:0]),
            .in_range     (CNT_W'(i) < limit),
            .left_gt      (l_gt),
            .left_value   (l_value),
            .left_col     (l_col),
            .left_valid   (l_valid),
            .right_value  (r_value[i]),
            .right_col    (r_col[i]),
            .right_valid  (r_valid[i]),
            .value        (c_value[i]),
            .col          (c_col[i]),
            .valid        (c_valid[i]),
            .gt           (c_gt[i])
        );
    end

    rtks_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (c_value[0]),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = (state_reg == ST_DIVGO);

    always_comb begin
        state_next    = state_reg;
        col_cnt_next  = col_cnt_reg;
        sum_next      = sum_reg;
        pass_cnt_next = pass_cnt_reg;
        out_col_next  = out_col_reg;
        out_w_next    = out_w_reg;
        out_end_next  = out_end_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept_in) begin
                    if (s_row_end) begin
                        col_cnt_next  = '0;
                        sum_next      = '0;
                        pass_cnt_next = '0;
                        state_next    = ST_SUM;
                    end else if (ctrl.ins_en) begin
                        col_cnt_next = col_cnt_reg + COLCNT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                // head of the rotating chain feeds the accumulator
                if (c_valid[0]) begin
                    sum_next = sum_reg + SUM_W'(c_value[0]);
                end
                pass_cnt_next = pass_cnt_reg + KIDX_W'(1);
                if (pass_cnt_reg == KIDX_W'(MAX_KEPT - 1)) begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO: begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (div_done) begin
                    out_col_next = c_col[0];
                    out_w_next   = div_q;
                    out_end_next = !r_valid[0];
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = out_end_reg ? ST_LOAD : ST_DIVGO;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        sum_reg     <= sum_next;
        out_col_reg <= out_col_next;
        out_w_reg   <= out_w_next;
        out_end_reg <= out_end_next;
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            top_count_reg <= TOP_COUNT_RESET;
            col_cnt_reg   <= '0;
            pass_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            col_cnt_reg  <= col_cnt_next;
            pass_cnt_reg <= pass_cnt_next;
            if (cfg_valid && cfg_ready) begin
                top_count_reg <= cfg_data;
            end
        end
    end

    assign m_column_index = out_col_reg;
    assign m_weight       = out_w_reg;
    assign m_run_end      = out_end_reg;

    // a sample that does not end the row leaves the block ready for the next
    a_load_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_row_end) |=> s_ready)
        else $error("input stalled after a mid-row sample");

    // a row always keeps at least one sample, so the head holds an entry
    a_head_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_row_end) |=> c_valid[0])
        else $error("empty list at row end");

    // a result on offer always comes from a live head entry
    a_out_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> c_valid[0])
        else $error("result offered from an empty cell");

    // the final result of a row returns the block to loading
    a_run_end_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_end) |=> (s_ready && !c_valid[0]))
        else $error("row not closed after last result");

endmodule

`default_nettype wire
